// ===== rtl/core/aer_pkg.sv =====
// shared constants, types and state codes of the adc event reframer
`timescale 1ns / 1ps

package aer_pkg;

  // word layout
  localparam int unsigned WORD_W         = 32;
  localparam logic [31:0] TYPE_MASK      = 32'h0700_0000;
  localparam logic [31:0] TYPE_HEADER    = 32'h0200_0000;
  localparam logic [31:0] TYPE_DATA      = 32'h0000_0000;
  localparam logic [31:0] COUNT_FIELD    = 32'h0000_3f00;
  localparam logic [31:0] COUNT_KEEP     = 32'hffff_c0ff;
  localparam int unsigned COUNT_POS      = 8;
  localparam int unsigned BYTES_W        = 8;

  // output stream data: word, byte count, overflow, clear request, zero pad
  localparam int unsigned M_TDATA_W      = 48;

  // default channel capacity of one event
  localparam int unsigned MAX_CHANNELS_DEF = 32;

  // finished event handed from the front end to the back end
  typedef struct packed {
    logic [WORD_W-1:0]  hdr;     // header with rewritten count field
    logic [WORD_W-1:0]  tail;    // word that ended the event
    logic [BYTES_W-1:0] bytes;   // event size in bytes, saturated
    logic               ovf;     // data words were dropped
    logic               clr;     // buffer clear request
    logic               bank;    // store bank holding the data words
  } evq_desc_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_HDR,
    BK_DATA,
    BK_END
  } back_state_e;

endpackage

// ===== rtl/core/aer_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module aer_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, output holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/aer_front.sv =====
// front end: classifies incoming words, collects one event into a store bank
`timescale 1ns / 1ps

module aer_front import aer_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1),
  localparam int unsigned AW    = IDX_W + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [WORD_W-1:0] s_word_i,
  input  logic              clear_after_read_i,
  input  logic              q_full_i,
  output logic              push_o,
  output evq_desc_t         push_desc_o,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [WORD_W-1:0] ram_wdata_o
);

  logic              collecting_q, collecting_d;
  logic              bank_q, bank_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [WORD_W-1:0] hdr_q, hdr_d;

  logic              take;
  logic              is_hdr;
  logic              is_data;
  logic              room;
  logic [8:0]        bytes_wide;

  // both banks busy means the queue is full, so all input waits
  assign s_ready_o = !q_full_i;
  assign take      = s_valid_i && s_ready_o;
  assign is_hdr    = (s_word_i & TYPE_MASK) == TYPE_HEADER;
  assign is_data   = (s_word_i & TYPE_MASK) == TYPE_DATA;
  assign room      = cnt_q < CNT_W'(MAX_CHANNELS);

  // store write for data words that still fit
  assign ram_we_o    = take && collecting_q && is_data && room;
  assign ram_waddr_o = {bank_q, cnt_q[IDX_W-1:0]};
  assign ram_wdata_o = s_word_i;

  // byte count of the finished event, saturated to eight bits
  assign bytes_wide = (9'(cnt_q) + 9'd2) << 2;

  // event descriptor for the back end
  always_comb begin
    push_desc_o.hdr   = (hdr_q & COUNT_KEEP) | ((32'(cnt_q) << COUNT_POS) & COUNT_FIELD);
    push_desc_o.tail  = s_word_i;
    push_desc_o.bytes = (bytes_wide > 9'd255) ? 8'hff : bytes_wide[7:0];
    push_desc_o.ovf   = ovf_q;
    push_desc_o.clr   = clear_after_read_i;
    push_desc_o.bank  = bank_q;
  end

  assign push_o = take && collecting_q && !is_data;

  // collection state
  always_comb begin
    collecting_d = collecting_q;
    bank_d       = bank_q;
    cnt_d        = cnt_q;
    ovf_d        = ovf_q;
    hdr_d        = hdr_q;
    if (take) begin
      if (!collecting_q) begin
        if (is_hdr) begin
          collecting_d = 1'b1;
          hdr_d        = s_word_i;
          cnt_d        = '0;
          ovf_d        = 1'b0;
        end
      end else if (is_data) begin
        if (room) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end else begin
        collecting_d = 1'b0;
        bank_d       = !bank_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      bank_q       <= 1'b0;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      hdr_q        <= '0;
    end else begin
      collecting_q <= collecting_d;
      bank_q       <= bank_d;
      cnt_q        <= cnt_d;
      ovf_q        <= ovf_d;
      hdr_q        <= hdr_d;
    end
  end

endmodule

// ===== rtl/core/aer_evq.sv =====
// two-entry queue of finished events between front and back end
`timescale 1ns / 1ps

module aer_evq import aer_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  evq_desc_t push_desc_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output evq_desc_t head_o
);

  evq_desc_t  entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q, fill_d;

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign head_o  = entry_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

  // fill level
  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      fill_q <= fill_d;
    end
  end

endmodule

// ===== rtl/core/aer_back.sv =====
// back end: emits header, stored data and ending word of each queued event
`timescale 1ns / 1ps

module aer_back import aer_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1),
  localparam int unsigned AW    = IDX_W + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  evq_desc_t            q_head_i,
  output logic                 q_pop_o,
  output logic                 ram_re_o,
  output logic [AW-1:0]        ram_raddr_o,
  input  logic [WORD_W-1:0]    ram_rdata_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [M_TDATA_W-1:0] m_data_o,
  output logic                 m_last_o
);

  back_state_e       state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q, out_word_d;
  logic [BYTES_W-1:0] out_bytes_q, out_bytes_d;
  logic              out_ovf_q, out_ovf_d;
  logic              out_clr_q, out_clr_d;
  logic              out_last_q, out_last_d;

  logic              slot_free;
  logic              load;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  idx_next;

  // output register can take a new word when empty or being drained
  assign slot_free = !out_valid_q || m_ready_i;
  assign cnt       = q_head_i.hdr[COUNT_POS +: CNT_W];
  assign idx_next  = idx_q + CNT_W'(1);

  // sequencer: one word per free cycle; the load ahead of a data word reads it
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    load        = 1'b0;
    q_pop_o     = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = {q_head_i.bank, idx_q[IDX_W-1:0]};
    out_word_d  = out_word_q;
    out_bytes_d = '0;
    out_last_d  = 1'b0;
    out_clr_d   = 1'b0;
    out_ovf_d   = q_head_i.ovf;
    unique case (state_q)
      BK_HDR: begin
        if (q_valid_i && slot_free) begin
          load       = 1'b1;
          out_word_d = q_head_i.hdr;
          idx_d      = '0;
          if (cnt != '0) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = {q_head_i.bank, {IDX_W{1'b0}}};
            state_d     = BK_DATA;
          end else begin
            state_d = BK_END;
          end
        end
      end
      BK_DATA: begin
        if (slot_free) begin
          load       = 1'b1;
          out_word_d = ram_rdata_i;
          if (idx_next < cnt) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = {q_head_i.bank, idx_next[IDX_W-1:0]};
            idx_d       = idx_next;
          end else begin
            state_d = BK_END;
          end
        end
      end
      BK_END: begin
        if (slot_free) begin
          load        = 1'b1;
          out_word_d  = q_head_i.tail;
          out_bytes_d = q_head_i.bytes;
          out_last_d  = 1'b1;
          out_clr_d   = q_head_i.clr;
          q_pop_o     = 1'b1;
          state_d     = BK_HDR;
        end
      end
      default: begin
        state_d = BK_HDR;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_HDR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q  <= out_word_d;
      out_bytes_q <= out_bytes_d;
      out_ovf_q   <= out_ovf_d;
      out_clr_q   <= out_clr_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_last_o  = out_last_q;
  assign m_data_o  = {6'b0, out_clr_q, out_ovf_q, out_bytes_q, out_word_q};

endmodule

// ===== rtl/core/adc_event_reframer.sv =====
// Reframes the word stream of a digitizer event buffer into complete events.
// Input words are taken at one per cycle unless the queue is full; a header
// (type 2 in bits 26:24) opens an event, data words (type 0) are stored up to
// MAX_CHANNELS and the first other word closes it. Each event comes out as
// the header with its count field rewritten, the stored data in arrival
// order and the closing word marked tlast, one word per cycle while tready
// is high, so n stored data words give n + 2 output words; an idle back end
// registers the header out once the queue holds the event. Two store banks
// in a ping-pong ram hold up to two closed events awaiting output; while
// both are held the input stalls, and tready returns the cycle after the
// back end loads the older event's closing word into its output register.
`timescale 1ns / 1ps

module adc_event_reframer import aer_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration: clear after read enable
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  // tdata [31:0] word_in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [WORD_W-1:0]    s_axis_tdata,
  // tdata [31:0] word_out, [39:32] event_bytes, [40] overflowed,
  // [41] clear_request, [47:42] zero
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tlast
);

  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned AW    = IDX_W + 1;

  logic              clear_q;
  logic              q_full;
  logic              q_push;
  evq_desc_t         q_push_desc;
  logic              q_pop;
  logic              q_valid;
  evq_desc_t         q_head;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q <= 1'b1;
    end else if (cfg_we_i) begin
      clear_q <= cfg_wdata_i;
    end
  end

  aer_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .s_valid_i          (s_axis_tvalid),
    .s_ready_o          (s_axis_tready),
    .s_word_i           (s_axis_tdata),
    .clear_after_read_i (clear_q),
    .q_full_i           (q_full),
    .push_o             (q_push),
    .push_desc_o        (q_push_desc),
    .ram_we_o           (ram_we),
    .ram_waddr_o        (ram_waddr),
    .ram_wdata_o        (ram_wdata)
  );

  aer_ram #(
    .WIDTH (WORD_W),
    .DEPTH (2 ** AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  aer_evq u_evq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (q_push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  aer_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

// ===== rtl/core/aer_checker.sv =====
// port level checks of the adc event reframer, bound to the top level
`timescale 1ns / 1ps

module aer_checker import aer_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [WORD_W-1:0]    s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  // a waiting input transfer keeps its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input transfer changed while waiting");

  // a stalled output transfer keeps its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output transfer changed while stalled");

  // closing word carries a whole number of words, at least header plus tail, or the saturated count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      (m_axis_tdata[33:32] == 2'b00 && m_axis_tdata[39:32] >= 8'd8)
      || m_axis_tdata[39:32] == 8'hff)
    else $error("bad byte count on closing word");

  // byte count and clear request only on the closing word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      m_axis_tdata[39:32] == 8'd0 && !m_axis_tdata[41])
    else $error("closing fields set on an inner word");

  // overflow mark of an inner word that is taken is repeated by a valid word directly behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
      m_axis_tdata[40] == $past(m_axis_tdata[40]))
    else $error("overflow mark changed within an event");

endmodule

bind adc_event_reframer aer_checker u_aer_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
